@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL of the signal-loss alarm.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/esla_pkg.sv @@
// Types and constants of the ECG signal-loss alarm.
// Used by ecg_signal_loss_alarm, its checker and its test; depends on nothing.
package esla_pkg;

  typedef enum logic [1:0] {
    MODE_SILENT = 2'd0,
    MODE_NOSIG  = 2'd1,
    MODE_RATE   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_NORMAL = 2'd0,
    STATUS_TACHY  = 2'd1,
    STATUS_BRADY  = 2'd2,
    STATUS_NOSIG  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_TICK       = 3'd0,
    REG_WARMUP     = 3'd1,
    REG_FIRST_BEAT = 3'd2,
    REG_BEAT_TO    = 3'd3,
    REG_RAIL_LOW   = 3'd4,
    REG_RAIL_HIGH  = 3'd5,
    REG_RAIL_TRIP  = 3'd6,
    REG_RAIL_MAX   = 3'd7
  } reg_index_t;

  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned RAIL_BITS = 12;
  localparam int unsigned CLIP_BITS = 13;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned PHASE_BITS = 16;

  localparam logic [7:0]            TICK_RESET       = 8'd2;
  localparam logic [15:0]           WARMUP_RESET     = 16'd3000;
  localparam logic [15:0]           FIRST_BEAT_RESET = 16'd6500;
  localparam logic [15:0]           BEAT_TO_RESET    = 16'd2500;
  localparam logic [RAIL_BITS-1:0]  RAIL_LOW_RESET   = 12'd30;
  localparam logic [RAIL_BITS-1:0]  RAIL_HIGH_RESET  = 12'd4065;
  localparam logic [CLIP_BITS-1:0]  RAIL_TRIP_RESET  = 13'd200;
  localparam logic [CLIP_BITS-1:0]  RAIL_MAX_RESET   = 13'd5000;

  localparam logic [PHASE_BITS-1:0] NOSIG_ON_MS  = 16'd200;
  localparam logic [PHASE_BITS-1:0] NOSIG_OFF_MS = 16'd800;
  localparam logic [PHASE_BITS-1:0] RATE_ON_MS   = 16'd100;
  localparam logic [PHASE_BITS-1:0] RATE_OFF_MS  = 16'd300;

endpackage

@@ hdl/ecg_signal_loss_alarm.sv @@
// ECG signal-loss alarm: timeouts, rail-clip counting and buzzer cadence.
// Depends on esla_pkg and assert_macros.svh.
// Each accepted sample word's result word is registered and valid in the next cycle.
// Throughput is one word per cycle; the output register takes a new word at the edge
// where its previous result leaves, so only a stalled full output holds input.
// Synchronous active-high reset restores register defaults and clears state.
`include "assert_macros.svh"

module ecg_signal_loss_alarm #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [esla_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [esla_pkg::DATA_BITS-1:0]     pwdata,
  output logic [esla_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [SAMPLE_BITS-1:0]             adc_sample,
  input  logic                               beat_updated,
  input  logic [1:0]                         rate_status,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               no_signal,
  output logic [1:0]                         alert_mode,
  output logic                               buzzer_on
);

  localparam int unsigned CMP_BITS =
    (SAMPLE_BITS > esla_pkg::RAIL_BITS) ? SAMPLE_BITS : esla_pkg::RAIL_BITS;

  logic [7:0]                          tick_ms;
  logic [15:0]                         warmup_ms;
  logic [15:0]                         first_beat_timeout_ms;
  logic [15:0]                         beat_timeout_ms;
  logic [esla_pkg::RAIL_BITS-1:0]      rail_low;
  logic [esla_pkg::RAIL_BITS-1:0]      rail_high;
  logic [esla_pkg::CLIP_BITS-1:0]      rail_trip;
  logic [esla_pkg::CLIP_BITS-1:0]      rail_max;

  logic [esla_pkg::TIME_BITS-1:0]      time_ms, time_ms_next;
  logic [esla_pkg::TIME_BITS-1:0]      last_beat_ms, last_beat_ms_next;
  logic                                beat_seen, beat_seen_next;
  logic [esla_pkg::CLIP_BITS-1:0]      clip_count, clip_count_next;
  esla_pkg::mode_t                     cadence_mode, cadence_mode_next;
  logic                                buzz_level, buzz_level_next;
  logic [esla_pkg::PHASE_BITS-1:0]     cadence_ms, cadence_ms_next;

  logic                                accept;
  logic                                cfg_write;
  esla_pkg::reg_index_t                cfg_sel;
  logic [CMP_BITS-1:0]                 sample_x, low_x, high_x;
  logic                                clipped;
  logic                                warm;
  logic                                forced;
  logic [esla_pkg::TIME_BITS-1:0]      beat_age;
  esla_pkg::mode_t                     mode;
  logic                                lvl_start;
  logic [esla_pkg::PHASE_BITS-1:0]     ph_start, ph_adv, on_ms, off_ms;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = esla_pkg::reg_index_t'(paddr[4:2]);
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    unique case (cfg_sel)
      esla_pkg::REG_TICK:       prdata = {24'd0, tick_ms};
      esla_pkg::REG_WARMUP:     prdata = {16'd0, warmup_ms};
      esla_pkg::REG_FIRST_BEAT: prdata = {16'd0, first_beat_timeout_ms};
      esla_pkg::REG_BEAT_TO:    prdata = {16'd0, beat_timeout_ms};
      esla_pkg::REG_RAIL_LOW:   prdata = {20'd0, rail_low};
      esla_pkg::REG_RAIL_HIGH:  prdata = {20'd0, rail_high};
      esla_pkg::REG_RAIL_TRIP:  prdata = {19'd0, rail_trip};
      esla_pkg::REG_RAIL_MAX:   prdata = {19'd0, rail_max};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms               <= esla_pkg::TICK_RESET;
      warmup_ms             <= esla_pkg::WARMUP_RESET;
      first_beat_timeout_ms <= esla_pkg::FIRST_BEAT_RESET;
      beat_timeout_ms       <= esla_pkg::BEAT_TO_RESET;
      rail_low              <= esla_pkg::RAIL_LOW_RESET;
      rail_high             <= esla_pkg::RAIL_HIGH_RESET;
      rail_trip             <= esla_pkg::RAIL_TRIP_RESET;
      rail_max              <= esla_pkg::RAIL_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        esla_pkg::REG_TICK:       tick_ms               <= pwdata[7:0];
        esla_pkg::REG_WARMUP:     warmup_ms             <= pwdata[15:0];
        esla_pkg::REG_FIRST_BEAT: first_beat_timeout_ms <= pwdata[15:0];
        esla_pkg::REG_BEAT_TO:    beat_timeout_ms       <= pwdata[15:0];
        esla_pkg::REG_RAIL_LOW:   rail_low              <= pwdata[esla_pkg::RAIL_BITS-1:0];
        esla_pkg::REG_RAIL_HIGH:  rail_high             <= pwdata[esla_pkg::RAIL_BITS-1:0];
        esla_pkg::REG_RAIL_TRIP:  rail_trip             <= pwdata[esla_pkg::CLIP_BITS-1:0];
        esla_pkg::REG_RAIL_MAX:   rail_max              <= pwdata[esla_pkg::CLIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    time_ms_next      = time_ms + {24'd0, tick_ms};
    last_beat_ms_next = beat_updated ? time_ms_next : last_beat_ms;
    beat_seen_next    = beat_seen || beat_updated;

    sample_x = CMP_BITS'(adc_sample);
    low_x    = CMP_BITS'(rail_low);
    high_x   = CMP_BITS'(rail_high);
    clipped  = (sample_x < low_x) || (sample_x > high_x);

    if (clipped) begin
      clip_count_next = (clip_count < rail_max) ? clip_count + 1'b1 : clip_count;
    end else begin
      clip_count_next = (clip_count != '0) ? clip_count - 1'b1 : clip_count;
    end

    warm     = time_ms_next >= {16'd0, warmup_ms};
    beat_age = time_ms_next - last_beat_ms_next;
    forced   = warm && ((!beat_seen_next && (time_ms_next >= {16'd0, first_beat_timeout_ms}))
                     || (beat_seen_next && (beat_age >= {16'd0, beat_timeout_ms}))
                     || (clip_count_next >= rail_trip));

    if (forced || rate_status == esla_pkg::STATUS_NOSIG) begin
      mode = esla_pkg::MODE_NOSIG;
    end else if (rate_status == esla_pkg::STATUS_TACHY ||
                 rate_status == esla_pkg::STATUS_BRADY) begin
      mode = esla_pkg::MODE_RATE;
    end else begin
      mode = esla_pkg::MODE_SILENT;
    end

    lvl_start = (mode != cadence_mode) ? 1'b1 : buzz_level;
    ph_start  = (mode != cadence_mode) ? '0 : cadence_ms;
    on_ms     = (mode == esla_pkg::MODE_NOSIG) ? esla_pkg::NOSIG_ON_MS : esla_pkg::RATE_ON_MS;
    off_ms    = (mode == esla_pkg::MODE_NOSIG) ? esla_pkg::NOSIG_OFF_MS : esla_pkg::RATE_OFF_MS;
    ph_adv    = ph_start + {8'd0, tick_ms};

    if (!warm || mode == esla_pkg::MODE_SILENT) begin
      cadence_mode_next = esla_pkg::MODE_SILENT;
      buzz_level_next   = 1'b0;
      cadence_ms_next   = '0;
    end else begin
      cadence_mode_next = mode;
      if (lvl_start) begin
        buzz_level_next = !(ph_adv >= on_ms);
        cadence_ms_next = (ph_adv >= on_ms) ? '0 : ph_adv;
      end else begin
        buzz_level_next = ph_adv >= off_ms;
        cadence_ms_next = (ph_adv >= off_ms) ? '0 : ph_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms      <= '0;
      last_beat_ms <= '0;
      beat_seen    <= 1'b0;
      clip_count   <= '0;
      cadence_mode <= esla_pkg::MODE_SILENT;
      buzz_level   <= 1'b0;
      cadence_ms   <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= accept || (out_valid && out_stall);
      if (accept) begin
        time_ms      <= time_ms_next;
        last_beat_ms <= last_beat_ms_next;
        beat_seen    <= beat_seen_next;
        clip_count   <= clip_count_next;
        cadence_mode <= cadence_mode_next;
        buzz_level   <= buzz_level_next;
        cadence_ms   <= cadence_ms_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      no_signal  <= forced;
      alert_mode <= mode;
      buzzer_on  <= buzz_level_next;
    end
  end

  `ASSERT_IMPLIES(a_buzz_needs_mode, clk, rst, out_valid && buzzer_on, alert_mode != esla_pkg::MODE_SILENT, "buzzer on while silent")
  `ASSERT_IMPLIES(a_forced_mode, clk, rst, out_valid && no_signal, alert_mode == esla_pkg::MODE_NOSIG, "forced no-signal without no-signal mode")
  `ASSERT_IMPLIES(a_idle_cadence, clk, rst, cadence_mode == esla_pkg::MODE_SILENT, !buzz_level && cadence_ms == '0, "cadence state not cleared")
  `ASSERT_NEXT(a_accept_result, clk, rst, accept, out_valid, "accepted word produced no result")

endmodule

@@ verif/ecg_signal_loss_alarm_checker.sv @@
// Checker for the ECG signal-loss alarm: watches the APB port and both word channels,
// predicts each result word and compares it field by field.
// Depends on esla_pkg; instantiated beside the block by ecg_signal_loss_alarm_test.
module ecg_signal_loss_alarm_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [esla_pkg::ADDR_BITS-1:0] paddr,
  input  logic [esla_pkg::DATA_BITS-1:0] pwdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [11:0]                    adc_sample,
  input  logic                           beat_updated,
  input  logic [1:0]                     rate_status,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           no_signal,
  input  logic [1:0]                     alert_mode,
  input  logic                           buzzer_on,
  output int                             errors,
  output int                             pending,
  output int                             checked_words,
  output int                             forced_words,
  output int                             buzz_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            no_signal;
    esla_pkg::mode_t mode;
    logic            buzz;
  } alarm_word_t;

  alarm_word_t expected_q[$];

  logic [7:0]  tick_ms;
  logic [15:0] warmup_ms;
  logic [15:0] first_beat_ms;
  logic [15:0] beat_to_ms;
  logic [11:0] rail_low;
  logic [11:0] rail_high;
  logic [12:0] rail_trip;
  logic [12:0] rail_max;

  logic [31:0]     now_ms;
  logic [31:0]     last_beat_ms;
  logic            beat_seen;
  logic [12:0]     clip_count;
  esla_pkg::mode_t cad_mode;
  logic            buzz;
  logic [15:0]     cadence_ms;

  function automatic alarm_word_t predict_alarm(input logic [11:0] sample, input logic beat,
                                                input esla_pkg::status_t status);
    logic            forced;
    esla_pkg::mode_t mode;
    logic [15:0]     on_ms;
    logic [15:0]     off_ms;
    alarm_word_t     w;
    forced = 1'b0;
    now_ms = now_ms + 32'(tick_ms);
    if (beat) begin
      last_beat_ms = now_ms;
      beat_seen = 1'b1;
    end
    if (sample < rail_low || sample > rail_high) begin
      if (clip_count < rail_max) clip_count = clip_count + 13'd1;
    end else if (clip_count != 13'd0) begin
      clip_count = clip_count - 13'd1;
    end
    if (now_ms >= 32'(warmup_ms)) begin
      if (!beat_seen) begin
        if (now_ms >= 32'(first_beat_ms)) forced = 1'b1;
      end else if (32'(now_ms - last_beat_ms) >= 32'(beat_to_ms)) begin
        forced = 1'b1;
      end
      if (clip_count >= rail_trip) forced = 1'b1;
    end
    if (forced || status == esla_pkg::STATUS_NOSIG) mode = esla_pkg::MODE_NOSIG;
    else if (status == esla_pkg::STATUS_TACHY || status == esla_pkg::STATUS_BRADY)
      mode = esla_pkg::MODE_RATE;
    else mode = esla_pkg::MODE_SILENT;
    if (now_ms < 32'(warmup_ms) || mode == esla_pkg::MODE_SILENT) begin
      cad_mode = esla_pkg::MODE_SILENT;
      buzz = 1'b0;
      cadence_ms = '0;
    end else begin
      if (mode != cad_mode) begin
        cad_mode = mode;
        buzz = 1'b1;
        cadence_ms = '0;
      end
      on_ms = (cad_mode == esla_pkg::MODE_NOSIG) ? esla_pkg::NOSIG_ON_MS : esla_pkg::RATE_ON_MS;
      off_ms = (cad_mode == esla_pkg::MODE_NOSIG) ? esla_pkg::NOSIG_OFF_MS
                                                  : esla_pkg::RATE_OFF_MS;
      cadence_ms = cadence_ms + 16'(tick_ms);
      if (buzz) begin
        if (cadence_ms >= on_ms) begin
          buzz = 1'b0;
          cadence_ms = '0;
        end
      end else if (cadence_ms >= off_ms) begin
        buzz = 1'b1;
        cadence_ms = '0;
      end
    end
    w.no_signal = forced;
    w.mode = mode;
    w.buzz = buzz;
    return w;
  endfunction

  always @(posedge clk) begin
    alarm_word_t want;
    if (rst) begin
      tick_ms = esla_pkg::TICK_RESET;
      warmup_ms = esla_pkg::WARMUP_RESET;
      first_beat_ms = esla_pkg::FIRST_BEAT_RESET;
      beat_to_ms = esla_pkg::BEAT_TO_RESET;
      rail_low = esla_pkg::RAIL_LOW_RESET;
      rail_high = esla_pkg::RAIL_HIGH_RESET;
      rail_trip = esla_pkg::RAIL_TRIP_RESET;
      rail_max = esla_pkg::RAIL_MAX_RESET;
      now_ms = '0;
      last_beat_ms = '0;
      beat_seen = 1'b0;
      clip_count = '0;
      cad_mode = esla_pkg::MODE_SILENT;
      buzz = 1'b0;
      cadence_ms = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (esla_pkg::reg_index_t'(paddr[4:2]))
          esla_pkg::REG_TICK:       tick_ms = pwdata[7:0];
          esla_pkg::REG_WARMUP:     warmup_ms = pwdata[15:0];
          esla_pkg::REG_FIRST_BEAT: first_beat_ms = pwdata[15:0];
          esla_pkg::REG_BEAT_TO:    beat_to_ms = pwdata[15:0];
          esla_pkg::REG_RAIL_LOW:   rail_low = pwdata[11:0];
          esla_pkg::REG_RAIL_HIGH:  rail_high = pwdata[11:0];
          esla_pkg::REG_RAIL_TRIP:  rail_trip = pwdata[12:0];
          esla_pkg::REG_RAIL_MAX:   rail_max = pwdata[12:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected: %s=%0b %s=%0d %s=%0b",
                   $time, "no_signal", no_signal, "alert_mode", alert_mode,
                   "buzzer_on", buzzer_on);
          errors++;
        end else begin
          want = expected_q.pop_front();
          checked_words++;
          if (want.no_signal) forced_words++;
          if (want.buzz) buzz_words++;
          if (no_signal !== want.no_signal) begin
            $display("%0t: no_signal expected %0b, got %0b", $time, want.no_signal, no_signal);
            errors++;
          end
          if (alert_mode !== want.mode) begin
            $display("%0t: alert_mode expected %0d, got %0d", $time, want.mode, alert_mode);
            errors++;
          end
          if (buzzer_on !== want.buzz) begin
            $display("%0t: buzzer_on expected %0b, got %0b", $time, want.buzz, buzzer_on);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_alarm(adc_sample, beat_updated,
                                           esla_pkg::status_t'(rate_status)));
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ verif/ecg_signal_loss_alarm_test.sv @@
// Top of the ECG signal-loss alarm testbench: clock, reset, APB register setup and
// sample stimulus with random gaps and output stalls; prints the verdict.
// Depends on esla_pkg, ecg_signal_loss_alarm and ecg_signal_loss_alarm_checker.
module ecg_signal_loss_alarm_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [esla_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [esla_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [esla_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [11:0]                    adc_sample = '0;
  logic                           beat_updated = 1'b0;
  logic [1:0]                     rate_status = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           no_signal;
  logic [1:0]                     alert_mode;
  logic                           buzzer_on;

  int errors;
  int pending;
  int checked_words;
  int forced_words;
  int buzz_words;

  int          words_sent = 0;
  int          settings_cnt = 0;
  int          burst_left = 0;
  logic        idle_en = 1'b1;
  logic [11:0] lo_rail = esla_pkg::RAIL_LOW_RESET;
  logic [11:0] hi_rail = esla_pkg::RAIL_HIGH_RESET;
  logic [15:0] stall_pat = '0;
  logic [5:0]  stall_cnt = '0;

  ecg_signal_loss_alarm dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .adc_sample(adc_sample), .beat_updated(beat_updated), .rate_status(rate_status),
    .out_valid(out_valid), .out_stall(out_stall),
    .no_signal(no_signal), .alert_mode(alert_mode), .buzzer_on(buzzer_on)
  );

  ecg_signal_loss_alarm_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .adc_sample(adc_sample), .beat_updated(beat_updated), .rate_status(rate_status),
    .out_valid(out_valid), .out_stall(out_stall),
    .no_signal(no_signal), .alert_mode(alert_mode), .buzzer_on(buzzer_on),
    .errors(errors), .pending(pending), .checked_words(checked_words),
    .forced_words(forced_words), .buzz_words(buzz_words)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 6'd1;
    if (stall_cnt == '0) begin
      case ($urandom_range(0, 3))
        0: stall_pat <= '0;
        1: stall_pat <= 16'($urandom);
        2: stall_pat <= 16'($urandom & $urandom);
        default: stall_pat <= 16'hFFF0;
      endcase
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    out_stall <= stall_pat[15];
  end

  task automatic send_word(input logic [11:0] sample, input logic beat,
                           input esla_pkg::status_t status);
    int gap;
    gap = 0;
    if (idle_en) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 9);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= sample;
    beat_updated <= beat;
    rate_status <= status;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input esla_pkg::reg_index_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_settings(input logic [7:0] tick, input logic [15:0] warmup,
                               input logic [15:0] first_beat, input logic [15:0] beat_to,
                               input logic [11:0] lo, input logic [11:0] hi,
                               input logic [12:0] trip, input logic [12:0] max_clip);
    write_reg(esla_pkg::REG_TICK, 32'(tick));
    write_reg(esla_pkg::REG_WARMUP, 32'(warmup));
    write_reg(esla_pkg::REG_FIRST_BEAT, 32'(first_beat));
    write_reg(esla_pkg::REG_BEAT_TO, 32'(beat_to));
    write_reg(esla_pkg::REG_RAIL_LOW, 32'(lo));
    write_reg(esla_pkg::REG_RAIL_HIGH, 32'(hi));
    write_reg(esla_pkg::REG_RAIL_TRIP, 32'(trip));
    write_reg(esla_pkg::REG_RAIL_MAX, 32'(max_clip));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    lo_rail = lo;
    hi_rail = hi;
    settings_cnt++;
  endtask

  // Status holds for random stretches so that the buzzer cadence can run its course.
  task automatic random_words(input int count, input int beat_pct, input int clip_pct);
    esla_pkg::status_t status;
    logic [11:0]       sample;
    status = esla_pkg::status_t'($urandom_range(0, 3));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) status = esla_pkg::status_t'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < clip_pct || lo_rail > hi_rail)
        sample = 12'($urandom_range(0, 4095));
      else sample = 12'($urandom_range(hi_rail, lo_rail));
      send_word(sample, $urandom_range(0, 99) < beat_pct, status);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_word(12'd0, 1'b0, esla_pkg::STATUS_NORMAL);
    send_word(12'd4095, 1'b0, esla_pkg::STATUS_TACHY);
    send_word(12'd29, 1'b0, esla_pkg::STATUS_BRADY);
    send_word(12'd30, 1'b0, esla_pkg::STATUS_NOSIG);
    send_word(12'd4065, 1'b0, esla_pkg::STATUS_NORMAL);
    send_word(12'd4066, 1'b0, esla_pkg::STATUS_TACHY);
    send_word(12'd2048, 1'b0, esla_pkg::STATUS_NORMAL);
    drain();

    load_settings(8'd100, 16'd0, 16'd500, 16'd300, 12'd30, 12'd4065, 13'd3, 13'd5);
    send_word(12'd1000, 1'b0, esla_pkg::STATUS_NORMAL);
    send_word(12'd1000, 1'b0, esla_pkg::STATUS_TACHY);
    send_word(12'd1000, 1'b0, esla_pkg::STATUS_TACHY);
    send_word(12'd1000, 1'b0, esla_pkg::STATUS_BRADY);
    send_word(12'd1000, 1'b0, esla_pkg::STATUS_NORMAL);
    send_word(12'd1000, 1'b1, esla_pkg::STATUS_NORMAL);
    send_word(12'd1000, 1'b0, esla_pkg::STATUS_NOSIG);
    send_word(12'd1000, 1'b0, esla_pkg::STATUS_NORMAL);
    send_word(12'd1000, 1'b0, esla_pkg::STATUS_NORMAL);
    send_word(12'd4095, 1'b1, esla_pkg::STATUS_NORMAL);
    send_word(12'd0, 1'b0, esla_pkg::STATUS_NORMAL);
    send_word(12'd4095, 1'b1, esla_pkg::STATUS_TACHY);
    send_word(12'd0, 1'b1, esla_pkg::STATUS_NORMAL);
    send_word(12'd0, 1'b1, esla_pkg::STATUS_NORMAL);
    send_word(12'd0, 1'b1, esla_pkg::STATUS_NORMAL);
    send_word(12'd2000, 1'b1, esla_pkg::STATUS_NORMAL);
    drain();

    idle_en = 1'b0;
    load_settings(8'd1, 16'd0, 16'd0, 16'd0, 12'd0, 12'd4095, 13'd0, 13'd0);
    random_words(50, 10, 30);
    drain();

    idle_en = 1'b1;
    load_settings(8'd255, 16'd65535, 16'd65535, 16'd65535, 12'd4095, 12'd0, 13'd8191, 13'd8191);
    random_words(50, 10, 30);
    drain();

    for (int p = 0; p < 7; p++) begin
      idle_en = (p % 3) != 0;
      load_settings(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                : 8'($urandom_range(20, 80)),
                    ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, 3000)),
                    16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 2500)),
                    ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300)),
                    ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(3800, 4095)),
                    13'($urandom_range(0, 60)),
                    (p == 0) ? 13'($urandom_range(0, 20))
                             : (($urandom_range(0, 5) == 0) ? 13'd8191
                                                            : 13'($urandom_range(0, 80))));
      random_words(65, $urandom_range(2, 40), $urandom_range(0, 50));
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Drove %0d sample words over %0d register settings; %0d result words checked.",
             words_sent, settings_cnt + 1, checked_words);
    $display("No-signal was forced on %0d results and the buzzer sounded on %0d.",
             forced_words, buzz_words);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d result words still expected.", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/esla_pkg.sv
hdl/ecg_signal_loss_alarm.sv
verif/ecg_signal_loss_alarm_checker.sv
verif/ecg_signal_loss_alarm_test.sv
